/* hdl/romdsc_pkg.sv */
package romdsc_pkg;

   // field widths
   localparam int INDEX_W = 24;
   localparam int WORD_W  = 32;
   localparam int LOW_W   = 16;
   localparam int MASK_N  = 16;
   localparam int KEY_N   = 4;

   // index bit where the word masks begin
   localparam int WORD_MASK_BASE = 2;

   typedef logic [4:0] bit_sel_type;
   typedef logic [1:0] key_sel_type;

   // starting value of the low address bits
   localparam logic [LOW_W-1:0] ADDR_SEED = 16'h92c6;

   // one address mask for each index bit 0..15
   localparam logic [LOW_W-1:0] ADDR_MASK [MASK_N] = '{
      16'hce4a, 16'h4db2, 16'hef60, 16'h5737, 16'h13dc, 16'h4bd9, 16'ha209, 16'hd996,
      16'ha700, 16'heca0, 16'h7529, 16'h3100, 16'h33b4, 16'h6161, 16'h1eef, 16'hf5a5
   };

   // one word mask for each index bit 2..17
   localparam logic [WORD_W-1:0] WORD_MASK [MASK_N] = '{
      32'h04400000, 32'h40000004, 32'h00048000, 32'h00000280,
      32'h00200040, 32'h09000000, 32'h00001100, 32'h20002000,
      32'h00000022, 32'h000a0000, 32'h10004000, 32'h00010400,
      32'h80000010, 32'h00000009, 32'h02100000, 32'h00800800
   };

   // word keys selected by index bits 1..0
   localparam logic [WORD_W-1:0] KEY [KEY_N] = '{
      32'hec63197a, 32'h58a5a55f, 32'he3a65f16, 32'h28d93783
   };

   // source bit for result bits 31 down to 0, one row per key
   localparam bit_sel_type PERM [KEY_N][WORD_W] = '{
      '{5'd1,  5'd4,  5'd7,  5'd28, 5'd22, 5'd18, 5'd20, 5'd9,
        5'd16, 5'd10, 5'd30, 5'd2,  5'd31, 5'd24, 5'd19, 5'd29,
        5'd6,  5'd21, 5'd23, 5'd11, 5'd12, 5'd13, 5'd5,  5'd0,
        5'd8,  5'd26, 5'd27, 5'd15, 5'd14, 5'd17, 5'd25, 5'd3},
      '{5'd14, 5'd23, 5'd28, 5'd29, 5'd6,  5'd24, 5'd10, 5'd1,
        5'd5,  5'd16, 5'd7,  5'd2,  5'd30, 5'd8,  5'd18, 5'd3,
        5'd31, 5'd22, 5'd25, 5'd20, 5'd17, 5'd0,  5'd19, 5'd27,
        5'd9,  5'd12, 5'd21, 5'd15, 5'd26, 5'd13, 5'd4,  5'd11},
      '{5'd19, 5'd30, 5'd21, 5'd4,  5'd2,  5'd18, 5'd15, 5'd1,
        5'd12, 5'd25, 5'd8,  5'd0,  5'd24, 5'd20, 5'd17, 5'd23,
        5'd22, 5'd26, 5'd28, 5'd16, 5'd9,  5'd27, 5'd6,  5'd11,
        5'd31, 5'd10, 5'd3,  5'd13, 5'd14, 5'd7,  5'd29, 5'd5},
      '{5'd30, 5'd6,  5'd15, 5'd0,  5'd31, 5'd18, 5'd26, 5'd22,
        5'd14, 5'd23, 5'd19, 5'd17, 5'd10, 5'd8,  5'd11, 5'd20,
        5'd1,  5'd28, 5'd2,  5'd4,  5'd9,  5'd24, 5'd25, 5'd27,
        5'd7,  5'd21, 5'd13, 5'd29, 5'd5,  5'd3,  5'd16, 5'd12}
   };

endpackage

/* hdl/romdsc_addr.sv */
module romdsc_addr (
   input  logic [romdsc_pkg::INDEX_W-1:0] word_index,
   output logic [romdsc_pkg::INDEX_W-1:0] source_address
);

   logic [romdsc_pkg::LOW_W-1:0] low_addr;

   // xor in one mask per set index bit
   always_comb begin
      low_addr = romdsc_pkg::ADDR_SEED;
      for (int k = 0; k < romdsc_pkg::MASK_N; k++) begin
         if (word_index[k]) begin
            low_addr = low_addr ^ romdsc_pkg::ADDR_MASK[k];
         end
      end
   end

   // upper bits pass straight from the index
   assign source_address = {word_index[romdsc_pkg::INDEX_W-1:romdsc_pkg::LOW_W], low_addr};

endmodule

/* hdl/romdsc_word.sv */
module romdsc_word (
   input  logic [romdsc_pkg::INDEX_W-1:0] word_index,
   input  logic [romdsc_pkg::WORD_W-1:0]  raw_word,
   output logic [romdsc_pkg::WORD_W-1:0]  plain_word
);

   logic [romdsc_pkg::WORD_W-1:0] masked_word;
   logic [romdsc_pkg::WORD_W-1:0] keyed_word;
   romdsc_pkg::key_sel_type       key_sel;

   assign key_sel = word_index[1:0];

   // xor in the two-bit masks for index bits 2..17
   always_comb begin
      masked_word = raw_word;
      for (int k = 0; k < romdsc_pkg::MASK_N; k++) begin
         if (word_index[k + romdsc_pkg::WORD_MASK_BASE]) begin
            masked_word = masked_word ^ romdsc_pkg::WORD_MASK[k];
         end
      end
   end

   assign keyed_word = masked_word ^ romdsc_pkg::KEY[key_sel];

   // bit shuffle matching the key, first table entry lands on the msb
   always_comb begin
      for (int k = 0; k < romdsc_pkg::WORD_W; k++) begin
         plain_word[romdsc_pkg::WORD_W-1-k] = keyed_word[romdsc_pkg::PERM[key_sel][k]];
      end
   end

endmodule

/* hdl/rom_word_address_and_data_descrambler_unit.sv */
// Program word descrambler.
// Command side: drive req_word_index and req_raw_word with start high; the
// transfer is taken at that clock edge whenever busy is low. busy stays low,
// so a new word may be started in every cycle.
// Result side: rsp_strobe is high for one cycle with rsp_source_address (the
// scrambled word address) and rsp_plain_word (the decrypted word). The
// receiver takes the result in that cycle and cannot hold it off.
// The start edge loads the input register; the result register is loaded from it
// in turn and drives the strobe, and all work between the two registers is xor
// and wiring. Throughput is one word per cycle.
// Reset (synchronous, active high) clears both valid flags; any transfer in
// flight is dropped and no strobe follows it.
module rom_word_address_and_data_descrambler_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [romdsc_pkg::INDEX_W-1:0]  req_word_index,
   input  logic [romdsc_pkg::WORD_W-1:0]   req_raw_word,
   output logic                            rsp_strobe,
   output logic [romdsc_pkg::INDEX_W-1:0]  rsp_source_address,
   output logic [romdsc_pkg::WORD_W-1:0]   rsp_plain_word
);

   logic                           req_valid_ff, req_valid_in;
   logic [romdsc_pkg::INDEX_W-1:0] index_ff;
   logic [romdsc_pkg::WORD_W-1:0]  raw_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [romdsc_pkg::INDEX_W-1:0] addr_ff, addr_in;
   logic [romdsc_pkg::WORD_W-1:0]  word_ff, word_in;

   // never stalls
   assign busy = 1'b0;

   assign req_valid_in = start & ~busy;
   assign rsp_valid_in = req_valid_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      if (req_valid_in) begin
         index_ff <= req_word_index;
         raw_ff   <= req_raw_word;
      end
   end

   // address scramble
   romdsc_addr u_addr (
      .word_index     (index_ff),
      .source_address (addr_in)
   );

   // word descramble
   romdsc_word u_word (
      .word_index (index_ff),
      .raw_word   (raw_ff),
      .plain_word (word_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_valid_in) begin
         addr_ff <= addr_in;
         word_ff <= word_in;
      end
   end

   assign rsp_strobe         = rsp_valid_ff;
   assign rsp_source_address = addr_ff;
   assign rsp_plain_word     = word_ff;

   // every started transfer gives exactly one strobe, once it passes the result register
   assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> rsp_strobe)
      else $error("started transfer produced no result");

   assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |=> !rsp_strobe)
      else $error("result strobe without a started transfer");

   // upper address bits follow the index of the matching transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_source_address[romdsc_pkg::INDEX_W-1:romdsc_pkg::LOW_W]
                     == $past(req_word_index[romdsc_pkg::INDEX_W-1:romdsc_pkg::LOW_W], 2))
      else $error("upper address bits do not match the index");

endmodule

/* test/rom_word_address_and_data_descrambler_unit_tb.sv */
`timescale 1ns / 100ps

module rom_word_address_and_data_descrambler_unit_tb;

   // field widths
   localparam int INDEX_W = romdsc_pkg::INDEX_W;
   localparam int WORD_W  = romdsc_pkg::WORD_W;

   // size of the program store in words
   localparam int STORE_WORDS = 524288;
   localparam int RANDOM_WORDS = 800;
   localparam int MAX_REPORTS = 10;

   // low address bits before any index bit is folded in
   localparam logic [15:0] LOW_START = 16'h92c6;

   // address xor per index bit 0..15
   localparam logic [0:15][15:0] LOW_XOR = {
      16'hce4a, 16'h4db2, 16'hef60, 16'h5737, 16'h13dc, 16'h4bd9, 16'ha209, 16'hd996,
      16'ha700, 16'heca0, 16'h7529, 16'h3100, 16'h33b4, 16'h6161, 16'h1eef, 16'hf5a5
   };

   // two-bit word xor per index bit 2..17
   localparam logic [0:15][31:0] DATA_XOR = {
      32'h04400000, 32'h40000004, 32'h00048000, 32'h00000280,
      32'h00200040, 32'h09000000, 32'h00001100, 32'h20002000,
      32'h00000022, 32'h000a0000, 32'h10004000, 32'h00010400,
      32'h80000010, 32'h00000009, 32'h02100000, 32'h00800800
   };

   // whole-word keys picked by index bits 1..0
   localparam logic [0:3][31:0] WORD_KEYS = {
      32'hec63197a, 32'h58a5a55f, 32'he3a65f16, 32'h28d93783
   };

   // bit routing per key: entry [k] is the source bit of result bit k
   localparam logic [0:3][31:0][4:0] BIT_SOURCE = {
      5'd1,  5'd4,  5'd7,  5'd28, 5'd22, 5'd18, 5'd20, 5'd9,
      5'd16, 5'd10, 5'd30, 5'd2,  5'd31, 5'd24, 5'd19, 5'd29,
      5'd6,  5'd21, 5'd23, 5'd11, 5'd12, 5'd13, 5'd5,  5'd0,
      5'd8,  5'd26, 5'd27, 5'd15, 5'd14, 5'd17, 5'd25, 5'd3,

      5'd14, 5'd23, 5'd28, 5'd29, 5'd6,  5'd24, 5'd10, 5'd1,
      5'd5,  5'd16, 5'd7,  5'd2,  5'd30, 5'd8,  5'd18, 5'd3,
      5'd31, 5'd22, 5'd25, 5'd20, 5'd17, 5'd0,  5'd19, 5'd27,
      5'd9,  5'd12, 5'd21, 5'd15, 5'd26, 5'd13, 5'd4,  5'd11,

      5'd19, 5'd30, 5'd21, 5'd4,  5'd2,  5'd18, 5'd15, 5'd1,
      5'd12, 5'd25, 5'd8,  5'd0,  5'd24, 5'd20, 5'd17, 5'd23,
      5'd22, 5'd26, 5'd28, 5'd16, 5'd9,  5'd27, 5'd6,  5'd11,
      5'd31, 5'd10, 5'd3,  5'd13, 5'd14, 5'd7,  5'd29, 5'd5,

      5'd30, 5'd6,  5'd15, 5'd0,  5'd31, 5'd18, 5'd26, 5'd22,
      5'd14, 5'd23, 5'd19, 5'd17, 5'd10, 5'd8,  5'd11, 5'd20,
      5'd1,  5'd28, 5'd2,  5'd4,  5'd9,  5'd24, 5'd25, 5'd27,
      5'd7,  5'd21, 5'd13, 5'd29, 5'd5,  5'd3,  5'd16, 5'd12
   };

   typedef struct packed {
      logic [INDEX_W-1:0] word_index;
      logic [WORD_W-1:0]  raw_word;
   } fetch_type;

   typedef struct packed {
      logic [INDEX_W-1:0] source_address;
      logic [WORD_W-1:0]  plain_word;
   } decoded_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [INDEX_W-1:0] req_word_index = '0;
   logic [WORD_W-1:0]  req_raw_word = '0;
   logic               rsp_strobe;
   logic [INDEX_W-1:0] rsp_source_address;
   logic [WORD_W-1:0]  rsp_plain_word;

   fetch_type   fetch_queue [$];
   decoded_type decoded_queue [$];
   int          issued_count = 0;
   int          error_count = 0;

   rom_word_address_and_data_descrambler_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_word_index     (req_word_index),
      .req_raw_word       (req_raw_word),
      .rsp_strobe         (rsp_strobe),
      .rsp_source_address (rsp_source_address),
      .rsp_plain_word     (rsp_plain_word)
   );

   always #1 clock = ~clock;

   // address scramble, word xor masks, key, then bit routing
   function automatic decoded_type descramble(input logic [INDEX_W-1:0] idx,
                                              input logic [WORD_W-1:0] raw);
      logic [15:0] low;
      logic [31:0] word;
      logic [31:0] routed;
      logic [1:0]  sel;
      decoded_type res;
      low = LOW_START;
      for (int k = 0; k < 16; k++)
         if (idx[k]) low = low ^ LOW_XOR[k];
      word = raw;
      for (int k = 0; k < 16; k++)
         if (idx[k+2]) word = word ^ DATA_XOR[k];
      sel = idx[1:0];
      word = word ^ WORD_KEYS[sel];
      for (int k = 0; k < 32; k++)
         routed[k] = word[BIT_SOURCE[sel][k]];
      res.source_address = {idx[23:16], low};
      res.plain_word = routed;
      return res;
   endfunction

   task automatic queue_fetch(input logic [INDEX_W-1:0] idx,
                              input logic [WORD_W-1:0] raw);
      fetch_type f;
      f.word_index = idx;
      f.raw_word = raw;
      fetch_queue.push_back(f);
   endtask

   // driver: record each accepted transfer, then present the next word or idle
   always @(posedge clock) begin
      int idle_pct;
      fetch_type f;
      idle_pct = (issued_count >= 300 && issued_count < 500) ? 0 : 35;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            decoded_queue.push_back(descramble(req_word_index, req_raw_word));
         if (!start || !busy) begin
            if (fetch_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
               f = fetch_queue.pop_front();
               req_word_index <= f.word_index;
               req_raw_word <= f.raw_word;
               start <= 1'b1;
               issued_count <= issued_count + 1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobe must match the oldest pending prediction
   always @(posedge clock) begin
      decoded_type want;
      if (!reset && rsp_strobe) begin
         if (decoded_queue.size() == 0) begin
            if (error_count < MAX_REPORTS)
               $display("unexpected result: address %h word %h",
                        rsp_source_address, rsp_plain_word);
            error_count <= error_count + 1;
         end else begin
            want = decoded_queue.pop_front();
            if (rsp_source_address !== want.source_address ||
                rsp_plain_word !== want.plain_word) begin
               if (error_count < MAX_REPORTS)
                  $display("mismatch: address exp %h got %h, word exp %h got %h",
                           want.source_address, rsp_source_address,
                           want.plain_word, rsp_plain_word);
               error_count <= error_count + 1;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [INDEX_W-1:0] idx;
      logic [WORD_W-1:0]  raw;
      int mode;
      // extremes of both fields
      queue_fetch(24'h000000, 32'h00000000);
      queue_fetch(24'hffffff, 32'hffffffff);
      queue_fetch(24'h000000, 32'hffffffff);
      queue_fetch(24'hffffff, 32'h00000000);
      // each key and its bit routing
      for (int s = 0; s < 4; s++) begin
         queue_fetch(24'(s), 32'h00000001);
         queue_fetch(24'(s), 32'h80000000);
         queue_fetch(24'h00fffc | 24'(s), 32'ha5a55a5a);
      end
      // index at the last store word and beyond the store size
      queue_fetch(24'(STORE_WORDS - 1), 32'h12345678);
      queue_fetch(24'(STORE_WORDS), 32'h12345678);
      queue_fetch(24'hff0000, 32'hdeadbeef);
      // top two word-mask bits and the highest address-mask bit
      queue_fetch(24'h020000, 32'h00000000);
      queue_fetch(24'h010000, 32'h00000000);
      queue_fetch(24'h008000, 32'h00000000);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         mode = $urandom_range(3);
         case (mode)
            0: begin
               idx = 24'($urandom);
               raw = $urandom;
            end
            1: begin
               idx = 24'h000001 << $urandom_range(INDEX_W - 1);
               raw = $urandom;
            end
            2: begin
               idx = 24'($urandom);
               raw = 32'h00000001 << $urandom_range(WORD_W - 1);
            end
            default: begin
               idx = 24'($urandom_range(STORE_WORDS - 1));
               raw = $urandom;
            end
         endcase
         queue_fetch(idx, raw);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (fetch_queue.size() != 0 || start || decoded_queue.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      if (error_count == 0 && decoded_queue.size() == 0)
         $display("PASS rom_word_address_and_data_descrambler_unit");
      else
         $display("FAIL rom_word_address_and_data_descrambler_unit");
      $finish;
   end

   // watchdog
   initial begin
      #200000;
      $display("FAIL rom_word_address_and_data_descrambler_unit");
      $finish;
   end

endmodule
